// ----- sv/sbsh_pkg.sv -----
// Shared types and constants for the SHA-256 byte stream hasher.
// No dependencies; modules reference members by scoped names.
package sbsh_pkg;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LENGTH_AT = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MARK,
    S_ZERO,
    S_LEN,
    S_COMPRESS,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t h_init(input logic [2:0] idx);
    case (idx)
      3'd0: h_init = 32'h6a09e667;
      3'd1: h_init = 32'hbb67ae85;
      3'd2: h_init = 32'h3c6ef372;
      3'd3: h_init = 32'ha54ff53a;
      3'd4: h_init = 32'h510e527f;
      3'd5: h_init = 32'h9b05688c;
      3'd6: h_init = 32'h1f83d9ab;
      default: h_init = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

// ----- sv/sha256_byte_stream_hasher_top.sv -----
// SHA-256 hasher over a byte stream: one absorb or finish item per handshake.
// An absorb item is taken while idle; the 64th byte of a block starts a compression
// (64 rounds of the shared round unit, one cycle per round, then one chaining add)
// Finish: mark byte, zeros, 64-bit length, one or two compressions, 8 result items.
// Reset (rst, synchronous): idle, chaining words at the initial hash, counts zero;
// the block buffer is not cleared.
// Depends on sbsh_pkg.
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  sbsh_pkg::state_t state, state_next;

  sbsh_pkg::word_t chain [8];
  sbsh_pkg::word_t s     [8];
  sbsh_pkg::word_t w     [16];

  logic [5:0]  fill;
  logic [63:0] byte_total;
  logic [63:0] len_bits;
  logic [5:0]  round;
  logic [2:0]  emit_idx;
  logic        finishing;
  logic        length_in;

  logic        shift_byte;
  logic [7:0]  shift_val;
  logic        emit_done;

  sbsh_pkg::word_t t1, t2, w_new;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sbsh_pkg::S_IDLE: begin
        if (item_valid) begin
          if (operation == sbsh_pkg::OP_FINISH) state_next = sbsh_pkg::S_MARK;
          else if (fill == sbsh_pkg::LAST_BYTE) state_next = sbsh_pkg::S_COMPRESS;
        end
      end
      sbsh_pkg::S_MARK: begin
        if (fill == sbsh_pkg::LAST_BYTE) state_next = sbsh_pkg::S_COMPRESS;
        else state_next = sbsh_pkg::S_ZERO;
      end
      sbsh_pkg::S_ZERO: begin
        if (fill == sbsh_pkg::LENGTH_AT) state_next = sbsh_pkg::S_LEN;
        else if (fill == sbsh_pkg::LAST_BYTE) state_next = sbsh_pkg::S_COMPRESS;
      end
      sbsh_pkg::S_LEN: begin
        if (fill == sbsh_pkg::LAST_BYTE) state_next = sbsh_pkg::S_COMPRESS;
      end
      sbsh_pkg::S_COMPRESS: begin
        if (round == sbsh_pkg::LAST_ROUND) state_next = sbsh_pkg::S_FOLD;
      end
      sbsh_pkg::S_FOLD: begin
        if (length_in) state_next = sbsh_pkg::S_EMIT;
        else if (finishing) state_next = sbsh_pkg::S_ZERO;
        else state_next = sbsh_pkg::S_IDLE;
      end
      sbsh_pkg::S_EMIT: begin
        if (emit_done) state_next = sbsh_pkg::S_IDLE;
      end
      default: state_next = sbsh_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    item_ready   = 1'b0;
    result_valid = 1'b0;
    shift_byte   = 1'b0;
    shift_val    = 8'h00;
    case (state)
      sbsh_pkg::S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && operation == sbsh_pkg::OP_ABSORB) begin
          shift_byte = 1'b1;
          shift_val  = data_byte;
        end
      end
      sbsh_pkg::S_MARK: begin
        shift_byte = 1'b1;
        shift_val  = sbsh_pkg::PAD_MARK;
      end
      sbsh_pkg::S_ZERO: begin
        shift_byte = (fill != sbsh_pkg::LENGTH_AT);
      end
      sbsh_pkg::S_LEN: begin
        shift_byte = 1'b1;
        shift_val  = len_bits[63:56];
      end
      sbsh_pkg::S_EMIT: begin
        result_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign emit_done   = result_ready && (emit_idx == sbsh_pkg::LAST_WORD_IDX);
  assign digest_word = chain[emit_idx];
  assign word_index  = emit_idx;
  assign last_word   = (emit_idx == sbsh_pkg::LAST_WORD_IDX);

  // Shared round unit and schedule extension
  assign t1 = s[7] + sbsh_pkg::big_sigma1(s[4]) + ((s[4] & s[5]) ^ (~s[4] & s[6]))
            + sbsh_pkg::round_k(round) + w[0];
  assign t2 = sbsh_pkg::big_sigma0(s[0]) + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
  assign w_new = w[0] + sbsh_pkg::small_sigma0(w[1]) + w[9] + sbsh_pkg::small_sigma1(w[14]);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbsh_pkg::S_IDLE;
      fill       <= '0;
      byte_total <= '0;
      round      <= '0;
      emit_idx   <= '0;
      finishing  <= 1'b0;
      length_in  <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= sbsh_pkg::h_init(3'(i));
    end else begin
      state <= state_next;
      if (shift_byte) fill <= fill + 6'd1;
      if (state == sbsh_pkg::S_IDLE && item_valid) begin
        if (operation == sbsh_pkg::OP_ABSORB) byte_total <= byte_total + 64'd1;
        else finishing <= 1'b1;
      end
      if (state == sbsh_pkg::S_LEN && fill == sbsh_pkg::LAST_BYTE) length_in <= 1'b1;
      if (state == sbsh_pkg::S_COMPRESS) round <= round + 6'd1;
      else round <= '0;
      if (state == sbsh_pkg::S_FOLD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + s[i];
      end
      if (state == sbsh_pkg::S_EMIT && result_ready) begin
        emit_idx <= emit_idx + 3'd1;
        // Start the next message once the final word is taken
        if (emit_done) begin
          byte_total <= '0;
          finishing  <= 1'b0;
          length_in  <= 1'b0;
          for (int i = 0; i < 8; i++) chain[i] <= sbsh_pkg::h_init(3'(i));
        end
      end
    end
  end

  // Payload registers: block window, working words, length
  always_ff @(posedge clk) begin
    if (state == sbsh_pkg::S_IDLE && item_valid && operation == sbsh_pkg::OP_FINISH) begin
      len_bits <= {byte_total[60:0], 3'b000};
    end else if (state == sbsh_pkg::S_LEN) begin
      len_bits <= {len_bits[55:0], 8'h00};
    end

    if (shift_byte) begin
      for (int i = 0; i < 15; i++) w[i] <= {w[i][23:0], w[i+1][31:24]};
      w[15] <= {w[15][23:0], shift_val};
    end else if (state == sbsh_pkg::S_COMPRESS) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end

    if (state != sbsh_pkg::S_COMPRESS && state_next == sbsh_pkg::S_COMPRESS) begin
      for (int i = 0; i < 8; i++) s[i] <= chain[i];
    end else if (state == sbsh_pkg::S_COMPRESS) begin
      s[7] <= s[6];
      s[6] <= s[5];
      s[5] <= s[4];
      s[4] <= s[3] + t1;
      s[3] <= s[2];
      s[2] <= s[1];
      s[1] <= s[0];
      s[0] <= t1 + t2;
    end
  end

endmodule

// ----- sv/sbsh_checker.sv -----
// Port-level checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on sbsh_pkg for the operation codes and the final word index.
module sbsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        operation,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // Hold off new items while a digest is going out
  a_no_accept_during_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !item_ready)
    else $error("item ready while digest words pending");

  // An absorb item never produces a result on the next cycle
  a_absorb_silent: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && operation == sbsh_pkg::OP_ABSORB) |=> !result_valid)
    else $error("result after absorb item");

  // Last flag marks exactly the final digest word
  a_last_matches_index: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (last_word == (word_index == sbsh_pkg::LAST_WORD_IDX)))
    else $error("last_word disagrees with word_index");

  // Words advance one at a time with no gap
  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !last_word) |=>
      (result_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // After the last word the block goes quiet and ready
  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last_word) |=> (!result_valid && item_ready))
    else $error("no return to idle after last word");

endmodule

bind sha256_byte_stream_hasher_top sbsh_checker u_sbsh_checker (.*);

// ----- test/sha256_byte_stream_hasher_top_test.sv -----
// Self-checking testbench for the SHA-256 byte stream hasher: random and directed messages,
// each digest predicted in the bench and checked word by word under random backpressure.
// Depends on sbsh_pkg and sha256_byte_stream_hasher_top.
module sha256_byte_stream_hasher_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        op;
    logic [7:0]  value;
    logic        drain;
  } stream_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        operation = sbsh_pkg::OP_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha256_byte_stream_hasher_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .operation    (operation),
    .data_byte    (data_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  logic [31:0] round_k_tab [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] iv_words [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Hash state tracked alongside the block
  logic [31:0] hash_state [0:7];
  logic [7:0]  msg_buf [0:63];
  int          msg_fill;
  logic [63:0] msg_len;

  stream_item_t pending_items [$];
  digest_out_t  digests_due [$];
  stream_item_t sending;

  int error_count = 0;
  int items_taken = 0;
  int words_checked = 0;
  int messages_queued = 0;
  int longest_msg = 0;
  int queued_items = 0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] d;
    d = {x, x} >> n;
    return d[31:0];
  endfunction

  function automatic void fold_block();
    logic [31:0] w [0:63];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x, y;
    int j;
    for (j = 0; j < 16; j++) begin
      w[j] = {msg_buf[4*j], msg_buf[4*j+1], msg_buf[4*j+2], msg_buf[4*j+3]};
    end
    for (j = 16; j < 64; j++) begin
      x = w[j-15];
      y = w[j-2];
      w[j] = w[j-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[j-7] +
             (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (j = 0; j < 64; j++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           round_k_tab[j] + w[j];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void restart_message();
    int j;
    for (j = 0; j < 8; j++) hash_state[j] = iv_words[j];
    msg_fill = 0;
    msg_len = 64'd0;
  endfunction

  // Advance the tracked hash by one accepted item; queue the digest on finish
  function automatic void predict_digest(input logic op, input logic [7:0] value);
    logic [63:0] bit_len;
    digest_out_t dw;
    int j;
    if (op == sbsh_pkg::OP_ABSORB) begin
      msg_buf[msg_fill] = value;
      msg_fill++;
      msg_len++;
      if (msg_fill == 64) begin
        fold_block();
        msg_fill = 0;
      end
    end else begin
      bit_len = msg_len << 3;
      msg_buf[msg_fill] = sbsh_pkg::PAD_MARK;
      msg_fill++;
      if (msg_fill > int'(sbsh_pkg::LENGTH_AT)) begin
        for (j = msg_fill; j < 64; j++) msg_buf[j] = 8'h00;
        fold_block();
        msg_fill = 0;
      end
      for (j = msg_fill; j < int'(sbsh_pkg::LENGTH_AT); j++) msg_buf[j] = 8'h00;
      for (j = 0; j < 8; j++) msg_buf[56 + j] = bit_len[63 - 8*j -: 8];
      fold_block();
      for (j = 0; j < 8; j++) begin
        dw.word = hash_state[j];
        dw.idx = j[2:0];
        dw.last = (j == 7);
        digests_due.push_back(dw);
      end
      restart_message();
    end
  endfunction

  function automatic void queue_item(input logic op, input logic [7:0] value,
                                     input logic drain);
    stream_item_t it;
    it.op = op;
    it.value = value;
    it.drain = drain;
    pending_items.push_back(it);
    queued_items++;
  endfunction

  // Random bytes of the given length, then a finish carrying a random ignored byte
  function automatic void queue_message(input int len, input logic drain);
    int j;
    for (j = 0; j < len; j++) begin
      queue_item(sbsh_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), drain && j == 0);
    end
    queue_item(sbsh_pkg::OP_FINISH, 8'($urandom_range(0, 255)), drain && len == 0);
    messages_queued++;
    if (len > longest_msg) longest_msg = len;
  endfunction

  function automatic bit steady_phase();
    return items_taken >= 150 && items_taken < 230;
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Driver
  always @(posedge clk) begin : feed
    logic busy;
    busy = item_valid && !item_ready;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        predict_digest(sending.op, sending.value);
        items_taken++;
      end
      if (!busy) begin
        if (pending_items.size() != 0 &&
            (steady_phase() || $urandom_range(0, 99) >= 13) &&
            !(pending_items[0].drain && digests_due.size() != 0)) begin
          sending = pending_items.pop_front();
          item_valid <= 1'b1;
          operation <= sending.op;
          data_byte <= sending.value;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and checker
  always @(posedge clk) begin : watch
    digest_out_t dw;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (digests_due.size() == 0) begin
          $error("unexpected result: digest_word %h word_index %0d", digest_word, word_index);
          error_count++;
        end else begin
          dw = digests_due.pop_front();
          words_checked++;
          if (digest_word !== dw.word) begin
            $error("digest_word mismatch: expected %h actual %h", dw.word, digest_word);
            error_count++;
          end
          if (word_index !== dw.idx) begin
            $error("word_index mismatch: expected %0d actual %0d", dw.idx, word_index);
            error_count++;
          end
          if (last_word !== dw.last) begin
            $error("last_word mismatch: expected %0d actual %0d", dw.last, last_word);
            error_count++;
          end
        end
      end
      // Hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_used && result_valid && items_taken >= 30) begin
        hold_used = 1'b1;
        hold_left = 300;
      end
      result_ready <= (hold_left == 0) && (steady_phase() || $urandom_range(0, 99) >= 13);
    end
  end

  initial begin : stimulus
    int r;
    int len;
    int edge_lens [0:5];
    edge_lens = '{55, 56, 57, 63, 64, 65};
    restart_message();

    // Empty message, "abc", byte extremes, a pad-like byte, back-to-back finishes
    queue_message(0, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'h61, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'h62, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'h63, 1'b0);
    queue_item(sbsh_pkg::OP_FINISH, 8'hff, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'h00, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'hff, 1'b0);
    queue_item(sbsh_pkg::OP_FINISH, 8'h00, 1'b0);
    queue_item(sbsh_pkg::OP_ABSORB, 8'h80, 1'b0);
    queue_item(sbsh_pkg::OP_FINISH, 8'h80, 1'b0);
    queue_item(sbsh_pkg::OP_FINISH, 8'h55, 1'b0);
    queue_item(sbsh_pkg::OP_FINISH, 8'haa, 1'b0);
    messages_queued += 5;

    // Pause before the random part until every digest is back
    r = 0;
    while (queued_items < 320) begin
      if ($urandom_range(0, 9) < 3) begin
        len = edge_lens[$urandom_range(0, 5)];
      end else begin
        len = $urandom_range(0, 20);
      end
      queue_message(len, r == 0);
      r++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || item_valid) @(posedge clk);
    while (digests_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Hashed %0d messages (%0d items, longest %0d bytes) under random stalls;",
             messages_queued, items_taken, longest_msg);
    $display("checked %0d digest words against the predicted hash.", words_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
